>>> sv/kwc_pkg.sv
// Shared types, constants and state encoding for the Kruskal wall carver.
`timescale 1ns / 1ps
`default_nettype none
package kwc_pkg;

  localparam int unsigned MAX_CELLS = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_CELLS);
  localparam int unsigned CNT_W     = ADDR_W + 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [3:0]        mask_t;

  localparam cnt_t  VCOUNT_RESET    = cnt_t'(MAX_CELLS);
  localparam cnt_t  VCOUNT_MAX      = cnt_t'(MAX_CELLS);
  localparam addr_t LAST_CELL       = addr_t'(MAX_CELLS - 1);

  localparam mask_t MASK_HORIZONTAL = 4'hB;
  localparam mask_t MASK_VERTICAL   = 4'hD;
  localparam mask_t MASK_NONE       = 4'hF;

  localparam logic MODE_CLEAR   = 1'b0;
  localparam logic MODE_JOIN    = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_ISSUE,
    ST_FIND_WALK,
    ST_COMP_WALK,
    ST_NEXT,
    ST_LINK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    addr_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic  merged;
    addr_t carve_cell;
    mask_t keep_mask;
    logic  status;
  } result_t;

endpackage
`default_nettype wire

>>> sv/kruskal_wall_carver.sv
// Top level: Kruskal wall carver with parent table memory and output register.
`timescale 1ns / 1ps
`default_nettype none
// Union-find engine for Kruskal-style wall removal. The parent table lives in a
// 1024-entry synchronous RAM; every access goes through a single sequencer,
// so one item is worked on at a time. After reset the block runs a clearing
// pass over all 1024 entries (in_ready low) before it takes its first item.
// A clear item goes through the accept, the sweep over every entry and the
// hand-off of the result. A join walks each cell up its chain to its root,
// one read per cycle, and a compression walk then points the cells on that
// path at the root; the length of a join thus depends on the depths da and
// db of the two cells below their roots. A join then links the two roots and
// hands off the result. An out-of-range join goes straight from the accept to
// the hand-off. The hand-off waits while the output register holds an
// unaccepted beat. The result sits in an output register, so a new item may
// be accepted while it waits. vertex_count values above 1024 act as 1024.
module kruskal_wall_carver import kwc_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [10:0] cfg_wdata,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_mode,
  input  wire [9:0]  in_vertex_a,
  input  wire [9:0]  in_vertex_b,
  input  wire        in_horizontal,
  input  wire        in_link_first_under_second,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       out_merged,
  output logic [9:0] out_carve_cell,
  output logic [3:0] out_keep_mask,
  output logic       out_status
);

  cnt_t     vcount_r;
  cnt_t     limit;
  mem_req_t mem_req;
  addr_t    rd_data;
  logic     res_valid;
  logic     res_ready;
  result_t  result;
  logic     out_valid_r;
  result_t  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  assign limit = (vcount_r > VCOUNT_MAX) ? VCOUNT_MAX : vcount_r;

  kwc_ctrl u_ctrl (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .mode                    (in_mode),
    .vertex_a                (in_vertex_a),
    .vertex_b                (in_vertex_b),
    .horizontal              (in_horizontal),
    .link_first_under_second (in_link_first_under_second),
    .limit                   (limit),
    .rd_data                 (rd_data),
    .mem_req                 (mem_req),
    .res_valid               (res_valid),
    .res_ready               (res_ready),
    .result                  (result)
  );

  kwc_parent_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_merged     = out_r.merged;
  assign out_carve_cell = out_r.carve_cell;
  assign out_keep_mask  = out_r.keep_mask;
  assign out_status     = out_r.status;

  a_reset_sweeps: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mem_req.we)
    else $error("parent table written while idle");

  a_merge_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_merged |-> out_status == STATUS_OK &&
      (out_keep_mask == MASK_HORIZONTAL || out_keep_mask == MASK_VERTICAL))
    else $error("merged beat with bad status or mask");

  a_nomerge_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_merged |-> out_keep_mask == MASK_NONE)
    else $error("unmerged beat with carving mask");

endmodule
`default_nettype wire

>>> sv/kwc_parent_ram.sv
// Parent table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kwc_parent_ram import kwc_pkg::*; (
  input  wire      clk,
  input  mem_req_t req,
  output addr_t    rd_data
);

  addr_t mem [MAX_CELLS];
  addr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> sv/kwc_ctrl.sv
// Sequencer: clear sweep, root walks with path compression, and root linking.
`timescale 1ns / 1ps
`default_nettype none
module kwc_ctrl import kwc_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  input  wire      mode,
  input  addr_t    vertex_a,
  input  addr_t    vertex_b,
  input  wire      horizontal,
  input  wire      link_first_under_second,
  input  cnt_t     limit,
  input  addr_t    rd_data,
  output mem_req_t mem_req,
  output logic     res_valid,
  input  wire      res_ready,
  output result_t  result
);

  state_t state_r, state_nxt;
  addr_t  clr_idx_r;
  logic   emit_r;
  addr_t  a_r, b_r, cur_r, root_r, ra_r;
  logic   horiz_r, link_r, sel_r, merged_r, status_r;
  addr_t  start;
  logic   out_of_range;
  logic   accept;

  assign start        = sel_r ? b_r : a_r;
  assign out_of_range = ({1'b0, vertex_a} >= limit) || ({1'b0, vertex_b} >= limit);
  assign accept       = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == LAST_CELL) begin
          state_nxt = emit_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (out_of_range) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_FIND_ISSUE;
          end
        end
      end
      ST_FIND_ISSUE: state_nxt = ST_FIND_WALK;
      ST_FIND_WALK: begin
        if (rd_data == cur_r) begin
          state_nxt = (start == cur_r) ? ST_NEXT : ST_COMP_WALK;
        end
      end
      ST_COMP_WALK: begin
        if (rd_data == root_r) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT:   state_nxt = sel_r ? ST_LINK : ST_FIND_ISSUE;
      ST_LINK:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_idx_r;
        mem_req.wdata = clr_idx_r;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_FIND_ISSUE: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = cur_r;
      end
      ST_FIND_WALK: begin
        if (rd_data != cur_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_data;
        end else if (start != cur_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = start;
        end
      end
      ST_COMP_WALK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur_r;
        mem_req.wdata = root_r;
        if (rd_data != root_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_data;
        end
      end
      ST_LINK: begin
        if (ra_r != root_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = link_r ? ra_r : root_r;
          mem_req.wdata = link_r ? root_r : ra_r;
        end
      end
      ST_FINISH: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      emit_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        clr_idx_r <= '0;
        emit_r    <= 1'b1;
      end else if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r      <= vertex_a;
      b_r      <= vertex_b;
      horiz_r  <= horizontal;
      link_r   <= link_first_under_second;
      cur_r    <= vertex_a;
      sel_r    <= 1'b0;
      merged_r <= 1'b0;
      status_r <= (mode == MODE_JOIN) && out_of_range ? STATUS_RANGE : STATUS_OK;
    end else begin
      case (state_r)
        ST_FIND_WALK: begin
          if (rd_data == cur_r) begin
            root_r <= cur_r;
            cur_r  <= start;
          end else begin
            cur_r <= rd_data;
          end
        end
        ST_COMP_WALK: cur_r <= rd_data;
        ST_NEXT: begin
          if (!sel_r) begin
            ra_r  <= root_r;
            sel_r <= 1'b1;
            cur_r <= b_r;
          end
        end
        ST_LINK: merged_r <= (ra_r != root_r);
        default: ;
      endcase
    end
  end

  assign result.merged     = merged_r;
  assign result.carve_cell = a_r;
  assign result.keep_mask  = merged_r ? (horiz_r ? MASK_HORIZONTAL : MASK_VERTICAL) : MASK_NONE;
  assign result.status     = status_r;

endmodule
`default_nettype wire
